// ===== rtl/core/dxt_block_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// DXT block decoder assertion macros
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_DEFINES_SVH
`define DXT_BLOCK_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define DXT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define DXT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DXT_ASSERT(lbl, prop, msg)
`define DXT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/dxt_pkg.sv =====
// ----------------------------------------------------------------------------
// DXT block decoder package
// Payload structs, format codes and register indexes of the decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

  localparam int CFG_DIM_W = 13;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } dxt_fmt_t;

  typedef enum logic [1:0] {
    CFG_FORMAT       = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } dxt_cfg_idx_t;

  localparam logic [3:0] PIX_LAST = 4'd15;

  typedef struct packed {
    logic [63:0] color_bits;
    logic [63:0] alpha_bits;
  } dxt_in_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        inside_res;
    logic        last;
  } dxt_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } dxt_rgb_t;

endpackage

// ===== rtl/core/dxt_block_decoder.sv =====
// ----------------------------------------------------------------------------
// DXT block decoder
// Expands DXT1, DXT3 and DXT5 compressed 4x4 blocks into RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   One beat on the in_ channel carries one compressed block (color half and
//   alpha half). The block produces sixteen beats on the out_ channel, one
//   pixel each, in raster order inside the block, tagged with image
//   coordinates; inside_res marks pixels within the configured image and last
//   marks the sixteenth pixel.
//   The palettes are built in the cycle a block is accepted and held in a
//   block register; a pixel select feeds the output register. The first pixel
//   passes from the block register through the pixel select into the output
//   register, where it is held until out_ready takes it.
//   Throughput is one pixel per cycle while out_ready stays high, set by the
//   single pixel output register. The next block is taken in the same cycle
//   the sixteenth pixel moves into the output register.
//   Format, width and height must be written through the cfg_ channel only while
//   the block is idle; the block itself does not enforce this. cfg_ready is always high.
//   Reset clears the block position to the image origin, drops any pending
//   block and pixel, and restores DXT1 with a 4x4 image.
//   When out_ready is low the output register holds its pixel and the block
//   register waits; a new block is refused until the current one has drained.
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_defines.svh"

module dxt_block_decoder
  import dxt_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dxt_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dxt_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_DIM_W-1:0] cfg_data
);

  localparam int DIM_W = ($clog2(MAX_DIMENSION + 1) > CFG_DIM_W) ?
                         $clog2(MAX_DIMENSION + 1) : CFG_DIM_W;
  localparam int BLK_W = $clog2((MAX_DIMENSION + 3) / 4 + 1);
  localparam int XW    = BLK_W + 2;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [7:0] n;
    logic [7:0] r;
    logic [2:0] q;
    n = 8'(v) * 8'd7;
    q = n[7:5];
    r = n - 8'(q) * 8'd31;
    if (r >= 8'd31) begin
      q = q + 3'd1;
    end
    return {v, 3'b000} + 8'(q);
  endfunction

  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [1:0] q;
    if (v >= 6'd63) q = 2'd3;
    else if (v >= 6'd42) q = 2'd2;
    else if (v >= 6'd21) q = 2'd1;
    else q = 2'd0;
    return {v, 2'b00} + 8'(q);
  endfunction

  // Reciprocal multiplies; exact over the operand ranges used here.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd1639;
    return p[20:13];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // ---------------------------------------------------------------- config
  logic [1:0]           fmt_cfg_r;
  logic [CFG_DIM_W-1:0] width_cfg_r;
  logic [CFG_DIM_W-1:0] height_cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_cfg_r    <= FMT_DXT1;
      width_cfg_r  <= CFG_DIM_W'(4);
      height_cfg_r <= CFG_DIM_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FORMAT:       fmt_cfg_r    <= cfg_data[1:0];
        CFG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;
  logic [DIM_W:0]   blk_w;
  logic [DIM_W:0]   blk_h;

  always_comb begin
    if (width_cfg_r == '0) img_w = DIM_W'(1);
    else if (DIM_W'(width_cfg_r) > DIM_W'(MAX_DIMENSION)) img_w = DIM_W'(MAX_DIMENSION);
    else img_w = DIM_W'(width_cfg_r);
    if (height_cfg_r == '0) img_h = DIM_W'(1);
    else if (DIM_W'(height_cfg_r) > DIM_W'(MAX_DIMENSION)) img_h = DIM_W'(MAX_DIMENSION);
    else img_h = DIM_W'(height_cfg_r);
    blk_w = ((DIM_W + 1)'(img_w) + (DIM_W + 1)'(3)) >> 2;
    blk_h = ((DIM_W + 1)'(img_h) + (DIM_W + 1)'(3)) >> 2;
  end

  // ---------------------------------------------------------------- palettes
  dxt_fmt_t    fmt_in;
  logic [15:0] c0;
  logic [15:0] c1;
  logic        four_color;
  logic [7:0]  e0 [3];
  logic [7:0]  e1 [3];
  logic [7:0]  m2 [3];
  logic [7:0]  m3 [3];
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic [7:0]  apal_nxt [8];
  logic [10:0] anum;

  always_comb begin
    case (fmt_cfg_r)
      FMT_DXT3: fmt_in = FMT_DXT3;
      FMT_DXT5: fmt_in = FMT_DXT5;
      default:  fmt_in = FMT_DXT1;
    endcase

    c0 = in_data.color_bits[15:0];
    c1 = in_data.color_bits[31:16];
    four_color = (c0 > c1) || (fmt_in != FMT_DXT1);
    e0[0] = exp5(c0[15:11]);
    e0[1] = exp6(c0[10:5]);
    e0[2] = exp5(c0[4:0]);
    e1[0] = exp5(c1[15:11]);
    e1[1] = exp6(c1[10:5]);
    e1[2] = exp5(c1[4:0]);
    for (int i = 0; i < 3; i++) begin
      if (four_color) begin
        m2[i] = div3({1'b0, e0[i], 1'b0} + 10'(e1[i]) + 10'd1);
        m3[i] = div3(10'(e0[i]) + {1'b0, e1[i], 1'b0} + 10'd1);
      end else begin
        m2[i] = 8'((9'(e0[i]) + 9'(e1[i])) >> 1);
        m3[i] = 8'd0;
      end
    end

    a0 = in_data.alpha_bits[7:0];
    a1 = in_data.alpha_bits[15:8];
    apal_nxt[0] = a0;
    apal_nxt[1] = a1;
    for (int k = 1; k <= 6; k++) begin
      if (a0 > a1) begin
        anum = 11'((7 - k) * a0) + 11'(k * a1) + 11'd3;
        apal_nxt[k + 1] = div7(anum);
      end else if (k <= 4) begin
        anum = 11'((5 - k) * a0) + 11'(k * a1) + 11'd2;
        apal_nxt[k + 1] = div5(anum);
      end else begin
        anum = '0;
        apal_nxt[k + 1] = (k == 5) ? 8'd0 : 8'd255;
      end
    end
  end

  // ---------------------------------------------------------------- block register
  logic             work_v_r;
  logic [3:0]       pix_r;
  dxt_fmt_t         fmt_r;
  dxt_rgb_t         cpal_r [4];
  logic             opaque3_r;
  logic [31:0]      cidx_r;
  logic [63:0]      abits_r;
  logic [7:0]       apal_r [8];
  logic [BLK_W-1:0] blk_col_r;
  logic [BLK_W-1:0] blk_row_r;
  logic [BLK_W-1:0] cur_col_r;
  logic [BLK_W-1:0] cur_row_r;
  logic [BLK_W-1:0] blk_col_nxt;
  logic [BLK_W-1:0] blk_row_nxt;
  logic [DIM_W:0]   col_inc;
  logic [DIM_W:0]   row_inc;

  logic     out_valid_r;
  dxt_out_t out_data_r;
  logic     emit;
  logic     accept;

  assign emit     = work_v_r && (!out_valid_r || out_ready);
  assign in_ready = !work_v_r || (emit && pix_r == PIX_LAST);
  assign accept   = in_valid && in_ready;

  // Raster walk over the block grid; a position beyond a shrunken grid restarts.
  always_comb begin
    col_inc = (DIM_W + 1)'(blk_col_r) + (DIM_W + 1)'(1);
    row_inc = (DIM_W + 1)'(blk_row_r);
    if (col_inc >= blk_w) begin
      col_inc = '0;
      row_inc = row_inc + (DIM_W + 1)'(1);
      if (row_inc >= blk_h) row_inc = '0;
    end
    if (row_inc >= blk_h) begin
      row_inc = '0;
      col_inc = '0;
    end
    blk_col_nxt = BLK_W'(col_inc);
    blk_row_nxt = BLK_W'(row_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_v_r  <= 1'b0;
      pix_r     <= '0;
      blk_col_r <= '0;
      blk_row_r <= '0;
    end else begin
      if (accept) begin
        work_v_r  <= 1'b1;
        pix_r     <= '0;
        blk_col_r <= blk_col_nxt;
        blk_row_r <= blk_row_nxt;
      end else if (emit) begin
        pix_r <= pix_r + 4'd1;
        if (pix_r == PIX_LAST) work_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fmt_r     <= fmt_in;
      cpal_r[0] <= '{r: e0[0], g: e0[1], b: e0[2]};
      cpal_r[1] <= '{r: e1[0], g: e1[1], b: e1[2]};
      cpal_r[2] <= '{r: m2[0], g: m2[1], b: m2[2]};
      cpal_r[3] <= '{r: m3[0], g: m3[1], b: m3[2]};
      opaque3_r <= four_color;
      cidx_r    <= in_data.color_bits[63:32];
      abits_r   <= in_data.alpha_bits;
      for (int i = 0; i < 8; i++) apal_r[i] <= apal_nxt[i];
      cur_col_r <= blk_col_r;
      cur_row_r <= blk_row_r;
    end
  end

  // ---------------------------------------------------------------- pixel select
  logic [1:0]    cidx;
  logic [2:0]    aidx;
  logic [5:0]    aidx_pos;
  logic [3:0]    nibble;
  dxt_rgb_t      pix_rgb;
  logic [7:0]    pix_alpha;
  logic [XW-1:0] pix_x;
  logic [XW-1:0] pix_y;
  dxt_out_t      pix_out;

  always_comb begin
    cidx      = cidx_r[{pix_r, 1'b0} +: 2];
    aidx_pos  = 6'd16 + 6'(pix_r) * 6'd3;
    aidx      = abits_r[aidx_pos +: 3];
    nibble    = abits_r[{pix_r, 2'b00} +: 4];
    pix_rgb   = cpal_r[cidx];
    case (fmt_r)
      FMT_DXT3: pix_alpha = {nibble, nibble};
      FMT_DXT5: pix_alpha = apal_r[aidx];
      default:  pix_alpha = (cidx == 2'd3 && !opaque3_r) ? 8'd0 : 8'd255;
    endcase
    pix_x = {cur_col_r, pix_r[1:0]};
    pix_y = {cur_row_r, pix_r[3:2]};
    pix_out.pixel_x    = 12'(pix_x);
    pix_out.pixel_y    = 12'(pix_y);
    pix_out.red        = pix_rgb.r;
    pix_out.green      = pix_rgb.g;
    pix_out.blue       = pix_rgb.b;
    pix_out.alpha      = pix_alpha;
    pix_out.inside_res = ((XW + DIM_W)'(pix_x) < (XW + DIM_W)'(img_w)) &&
                         ((XW + DIM_W)'(pix_y) < (XW + DIM_W)'(img_h));
    pix_out.last       = (pix_r == PIX_LAST);
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= pix_out;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- assertions
  `DXT_ASSERT(a_accept_starts_block, (in_valid && in_ready) |=> (work_v_r && pix_r == '0),
              "accepted block did not start at pixel zero")
  `DXT_ASSERT(a_no_accept_mid_block, (work_v_r && pix_r != PIX_LAST) |-> !in_ready,
              "input ready while a block is still being expanded")
  `DXT_ASSERT(a_last_on_final_pixel, (emit && pix_r == PIX_LAST) |=> (out_valid && out_data.last),
              "sixteenth pixel not flagged as last")
  `DXT_ASSERT_ALWAYS(a_reset_clears_output, !rst_n |=> !out_valid,
                     "output valid after reset")

endmodule

// ===== dv/dxt_pixel_check_pkg.sv =====
// ----------------------------------------------------------------------------
// DXT pixel expectation tracker
// Predicts the sixteen RGBA pixels of every accepted compressed block and
// checks the decoder's pixel beats against them in order.
// ----------------------------------------------------------------------------
package dxt_pixel_check_pkg;
  import dxt_pkg::*;

  localparam int MAX_DIMENSION = 4096;

  class dxt_pixel_tracker;
    logic [1:0]          format_reg;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    int                  blk_col;
    int                  blk_row;
    dxt_out_t            pending_pixels[$];
    int                  fail_count;

    function new();
      format_reg = FMT_DXT1;
      width_reg  = 4;
      height_reg = 4;
      blk_col    = 0;
      blk_row    = 0;
      fail_count = 0;
    endfunction

    function void write_reg(dxt_cfg_idx_t idx, logic [CFG_DIM_W-1:0] value);
      case (idx)
        CFG_FORMAT:       format_reg = value[1:0];
        CFG_IMAGE_WIDTH:  width_reg  = value;
        CFG_IMAGE_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    static function int effective_dim(logic [CFG_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return int'(v);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    // Expands one accepted block into its sixteen pixels and moves the block
    // position on.
    function void predict_block(dxt_in_t blk);
      dxt_fmt_t       fmt;
      logic [15:0]    c565;
      int             ep[2][3];
      int             pal[4][3];
      int             pal_a[4];
      int             apal[8];
      int             a0, a1, w, h, x, y, ci;
      bit             four_color;
      dxt_out_t       px;
      fmt = (format_reg == FMT_DXT3 || format_reg == FMT_DXT5) ?
            dxt_fmt_t'(format_reg) : FMT_DXT1;
      w = effective_dim(width_reg);
      h = effective_dim(height_reg);

      for (int e = 0; e < 2; e++) begin
        c565 = blk.color_bits[16*e +: 16];
        ep[e][0] = int'(c565[15:11]) * 255 / 31;
        ep[e][1] = int'(c565[10:5]) * 255 / 63;
        ep[e][2] = int'(c565[4:0]) * 255 / 31;
      end
      four_color = (blk.color_bits[15:0] > blk.color_bits[31:16]) || (fmt != FMT_DXT1);
      for (int ch = 0; ch < 3; ch++) begin
        pal[0][ch] = ep[0][ch];
        pal[1][ch] = ep[1][ch];
        if (four_color) begin
          pal[2][ch] = (2 * ep[0][ch] + ep[1][ch] + 1) / 3;
          pal[3][ch] = (ep[0][ch] + 2 * ep[1][ch] + 1) / 3;
        end else begin
          pal[2][ch] = (ep[0][ch] + ep[1][ch]) / 2;
          pal[3][ch] = 0;
        end
      end
      pal_a[0] = 255;
      pal_a[1] = 255;
      pal_a[2] = 255;
      pal_a[3] = four_color ? 255 : 0;

      a0 = int'(blk.alpha_bits[7:0]);
      a1 = int'(blk.alpha_bits[15:8]);
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
        for (int k = 1; k <= 6; k++) apal[k+1] = ((7 - k) * a0 + k * a1 + 3) / 7;
      end else begin
        for (int k = 1; k <= 4; k++) apal[k+1] = ((5 - k) * a0 + k * a1 + 2) / 5;
        apal[6] = 0;
        apal[7] = 255;
      end

      for (int p = 0; p < 16; p++) begin
        x  = blk_col * 4 + p % 4;
        y  = blk_row * 4 + p / 4;
        ci = int'(blk.color_bits[32 + 2*p +: 2]);
        px.pixel_x = 12'(x);
        px.pixel_y = 12'(y);
        px.red     = 8'(pal[ci][0]);
        px.green   = 8'(pal[ci][1]);
        px.blue    = 8'(pal[ci][2]);
        case (fmt)
          FMT_DXT3: px.alpha = 8'(int'(blk.alpha_bits[4*p +: 4]) * 17);
          FMT_DXT5: px.alpha = 8'(apal[blk.alpha_bits[16 + 3*p +: 3]]);
          default:  px.alpha = 8'(pal_a[ci]);
        endcase
        px.inside_res = (x < w) && (y < h);
        px.last       = (4'(p) == PIX_LAST);
        pending_pixels.push_back(px);
      end

      // A shrunken grid can leave the position past its end; it then restarts
      // at the origin.
      blk_col++;
      if (blk_col >= (w + 3) / 4) begin
        blk_col = 0;
        blk_row++;
        if (blk_row >= (h + 3) / 4) blk_row = 0;
      end
      if (blk_row >= (h + 3) / 4) begin
        blk_row = 0;
        blk_col = 0;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        fail_count++;
        $error("pixel field %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_pixel(dxt_out_t got);
      dxt_out_t want;
      if (pending_pixels.size() == 0) begin
        fail_count++;
        $error("pixel beat x=%0d y=%0d with no expected pixel waiting",
               got.pixel_x, got.pixel_y);
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("inside_res", want.inside_res, got.inside_res);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

// ===== dv/tb_dxt_block_decoder.sv =====
// ----------------------------------------------------------------------------
// DXT block decoder testbench
// Feeds directed and random DXT1/DXT3/DXT5 blocks under a range of formats
// and image sizes, with random stalls on both channels, and checks every
// pixel beat against a predicted pixel stream.
// ----------------------------------------------------------------------------
module tb_dxt_block_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import dxt_pkg::*;
  import dxt_pixel_check_pkg::*;

  localparam int LONG_STALL_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BLOCKS = 100;
  localparam int STEADY_BLOCKS = 20;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  dxt_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dxt_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = CFG_FORMAT;
  logic [CFG_DIM_W-1:0] cfg_data = '0;

  dxt_pixel_tracker     sb;
  bit                   steady = 1'b0;
  bit                   long_stall_req = 1'b0;
  int                   idle_cycles = 0;

  dxt_block_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_pixel(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pixel receiver: random stall bursts, one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES - 1) @(negedge clk);
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_block(input dxt_in_t blk);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 2) == 0)
      gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (!in_ready);
    sb.predict_block(blk);
  endtask

  // Drops the block channel and waits until every predicted pixel has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input dxt_cfg_idx_t idx, input logic [CFG_DIM_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DIM_W-1:0] fmt_word,
                            input logic [CFG_DIM_W-1:0] w,
                            input logic [CFG_DIM_W-1:0] h);
    wait_drained();
    write_reg(CFG_FORMAT, fmt_word);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  function automatic dxt_in_t random_block();
    dxt_in_t blk;
    blk.color_bits = {$urandom, $urandom};
    blk.alpha_bits = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: blk.color_bits[31:16] = blk.color_bits[15:0];
      1: blk.alpha_bits[15:8] = blk.alpha_bits[7:0];
      default: ;
    endcase
    return blk;
  endfunction

  // Mostly small images, with the out-of-range and largest sizes mixed in.
  function automatic logic [CFG_DIM_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DIM_W'(MAX_DIMENSION);
      2:       return CFG_DIM_W'($urandom_range(MAX_DIMENSION + 1, 8191));
      3:       return CFG_DIM_W'($urandom_range(1, MAX_DIMENSION));
      default: return CFG_DIM_W'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    int sent;
    int n;
    int phase_cnt;
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // DXT1 at the reset settings: equal, three-color and four-color endpoints.
    send_block({64'h0, 64'h0});
    send_block({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
    send_block({64'hE4E4_E4E4_0000_FFFF, 64'h0});
    send_block({64'hE4E4_E4E4_FFFF_0000, 64'h0});
    send_block({64'h1B1B_1B1B_7BEF_7BF0, 64'h5A5A_A5A5_0F0F_F0F0});

    // DXT3 keeps four colors even when c0 is not above c1.
    set_config(FMT_DXT3, 13'd4, 13'd4);
    send_block({64'hE4E4_E4E4_F800_001F, 64'hFEDC_BA98_7654_3210});
    send_block({64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF});

    // DXT5: eight-step, six-step, equal and adjacent alpha endpoints.
    set_config(FMT_DXT5, 13'd4, 13'd4);
    send_block({64'hE4E4_E4E4_07E0_F81F, {48'hFAC6_88FA_C688, 8'h00, 8'hFF}});
    send_block({64'h1B1B_1B1B_F81F_07E0, {48'hFAC6_88FA_C688, 8'hFF, 8'h00}});
    send_block({64'hE4E4_E4E4_FFFF_FFFF, {48'hFAC6_88FA_C688, 8'h80, 8'h80}});
    send_block({64'h0000_0000_0000_0000, {48'hFAC6_88FA_C688, 8'h80, 8'h81}});

    // The unused format code decodes as DXT1.
    set_config(13'h1FFF, 13'd4, 13'd4);
    send_block({64'hE4E4_E4E4_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF});

    // Zero dimensions count as one pixel; oversized ones clamp to the maximum.
    set_config(FMT_DXT1, 13'd0, 13'd0);
    repeat (2) send_block(random_block());
    set_config(FMT_DXT5, 13'h1FFF, 13'd4097);
    repeat (2) send_block(random_block());

    // Partial edge blocks flag their outside pixels.
    set_config(FMT_DXT3, 13'd5, 13'd3);
    repeat (4) send_block(random_block());

    // Shrinking the image below the current block row restarts at the origin.
    set_config(FMT_DXT1, 13'd4, 13'd64);
    repeat (3) send_block(random_block());
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 13'd4);
    repeat (2) send_block(random_block());

    sent = 0;
    phase_cnt = 0;
    while (sent < RANDOM_BLOCKS) begin
      n = $urandom_range(4, 16);
      set_config(CFG_DIM_W'($urandom), random_dim(), random_dim());
      // The block fills up behind a held pixel beat and stalls its input.
      if (phase_cnt == 1) long_stall_req = 1'b1;
      repeat (n) send_block(random_block());
      sent += n;
      phase_cnt++;
    end

    set_config(FMT_DXT5, 13'd12, 13'd9);
    steady = 1'b1;
    repeat (STEADY_BLOCKS) send_block(random_block());

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
